FILE: rtl/core/pbs_pkg.sv
`default_nettype none
package pbs_pkg;

    localparam int RANGE_W = 16;
    localparam int IDX_W = 9;
    localparam int FRAME_W = 16;
    localparam int HEIGHT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int EDGE_STEP = 800;

    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LAST = 3'd4;

    localparam logic [IDX_W-1:0] WINDOW_FIRST_RESET = 9'd1;
    localparam logic [IDX_W-1:0] WINDOW_LAST_RESET = 9'd273;

    typedef struct packed {
        logic [HEIGHT_W-1:0] mount_height;
        logic [HEIGHT_W-1:0] min_height;
        logic [IDX_W-1:0]    min_width;
        logic [IDX_W-1:0]    window_first;
        logic [IDX_W-1:0]    window_last;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] raw_range;
        logic [IDX_W-1:0]   sample_index;
        logic [FRAME_W-1:0] frame_id;
    } sample_t;

    typedef struct packed {
        logic [IDX_W-1:0]    seg_start;
        logic [IDX_W-1:0]    seg_finish;
        logic [HEIGHT_W-1:0] peak_height;
        logic [IDX_W-1:0]    peak_index;
        logic [FRAME_W-1:0]  seg_frame;
    } segment_t;

    typedef struct packed {
        logic     produced;
        segment_t segment;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/pbs_sample_if.sv
`default_nettype none
interface pbs_sample_if;
    import pbs_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] raw_range;
    logic [IDX_W-1:0]   sample_index;
    logic [FRAME_W-1:0] frame_id;

    modport source (output valid, output raw_range, output sample_index, output frame_id,
                    input ready);
    modport sink (input valid, input raw_range, input sample_index, input frame_id,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pbs_segment_if.sv
`default_nettype none
interface pbs_segment_if;
    import pbs_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    seg_start;
    logic [IDX_W-1:0]    seg_finish;
    logic [HEIGHT_W-1:0] peak_height;
    logic [IDX_W-1:0]    peak_index;
    logic [FRAME_W-1:0]  seg_frame;

    modport source (output valid, output seg_start, output seg_finish, output peak_height,
                    output peak_index, output seg_frame, input ready);
    modport sink (input valid, input seg_start, input seg_finish, input peak_height,
                  input peak_index, input seg_frame, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pbs_in_stage.sv
`default_nettype none
module pbs_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    pbs_sample_if.sink            samples,
    input  wire logic             advance,
    output logic                  stage_valid,
    output pbs_pkg::sample_t      stage_sample
);
    import pbs_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sample_t sample_reg;
    logic    take;

    assign samples.ready = !valid_reg || advance;
    assign take = samples.valid && samples.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= '{raw_range: samples.raw_range,
                            sample_index: samples.sample_index,
                            frame_id: samples.frame_id};
        end
    end

    assign stage_valid = valid_reg;
    assign stage_sample = sample_reg;
endmodule
`default_nettype wire

FILE: rtl/core/pbs_tracker.sv
`default_nettype none
module pbs_tracker #(
    parameter int SAMPLES_PER_FRAME = 274
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pbs_pkg::cfg_t    cfg,
    input  wire logic             advance,
    input  wire pbs_pkg::sample_t stage_sample,
    output pbs_pkg::result_t      result
);
    import pbs_pkg::*;

    localparam logic [31:0] INDEX_LIMIT = 32'(SAMPLES_PER_FRAME);
    localparam logic signed [HEIGHT_W:0] STEP_UP = (HEIGHT_W+1)'(EDGE_STEP);
    localparam logic signed [HEIGHT_W:0] STEP_DOWN = (HEIGHT_W+1)'(-EDGE_STEP);

    logic [HEIGHT_W-1:0] prev_height_reg, prev_height_next;
    logic                in_segment_reg, in_segment_next;
    logic [IDX_W-1:0]    open_start_reg, open_start_next;
    logic [HEIGHT_W-1:0] open_peak_reg, open_peak_next;
    logic [IDX_W-1:0]    open_peak_index_reg, open_peak_index_next;

    logic [HEIGHT_W:0]        raw_height;
    logic [HEIGHT_W-1:0]      height;
    logic signed [HEIGHT_W:0] diff;
    logic [IDX_W-1:0]         idx;
    logic                     in_window;
    logic signed [IDX_W+1:0]  width;
    logic                     wide_enough;

    assign idx = stage_sample.sample_index;
    assign raw_height = {1'b0, cfg.mount_height} - {1'b0, stage_sample.raw_range};

    // A negative difference or one below the minimum becomes zero.
    assign height = (raw_height[HEIGHT_W] || (raw_height[HEIGHT_W-1:0] < cfg.min_height))
                    ? '0 : raw_height[HEIGHT_W-1:0];
    assign diff = $signed({1'b0, height}) - $signed({1'b0, prev_height_reg});

    assign in_window = (idx >= cfg.window_first) && (idx <= cfg.window_last) &&
                       ({{(32-IDX_W){1'b0}}, idx} < INDEX_LIMIT);

    assign width = $signed({2'b00, idx}) - $signed((IDX_W+2)'(1))
                   - $signed({2'b00, open_start_reg});
    assign wide_enough = !width[IDX_W+1] && (width[IDX_W:0] >= {1'b0, cfg.min_width});

    always_comb
    begin
        prev_height_next = height;
        in_segment_next = in_segment_reg;
        open_start_next = open_start_reg;
        open_peak_next = open_peak_reg;
        open_peak_index_next = open_peak_index_reg;
        result.produced = 1'b0;
        result.segment.seg_start = open_start_reg;
        result.segment.seg_finish = idx - IDX_W'(1);
        result.segment.peak_height = open_peak_reg;
        result.segment.peak_index = open_peak_index_reg;
        result.segment.seg_frame = stage_sample.frame_id;
        if (idx == '0)
        begin
            in_segment_next = 1'b0;
        end
        else if (in_window)
        begin
            if (diff > STEP_UP)
            begin
                in_segment_next = 1'b1;
                open_start_next = idx;
                open_peak_next = height;
                open_peak_index_next = idx;
            end
            else if (diff < STEP_DOWN)
            begin
                result.produced = advance && in_segment_reg && wide_enough;
                in_segment_next = 1'b0;
            end
            else if (in_segment_reg && (height > open_peak_reg))
            begin
                open_peak_next = height;
                open_peak_index_next = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_height_reg <= '0;
            in_segment_reg <= 1'b0;
            open_start_reg <= '0;
            open_peak_reg <= '0;
            open_peak_index_reg <= '0;
        end
        else if (advance)
        begin
            prev_height_reg <= prev_height_next;
            in_segment_reg <= in_segment_next;
            open_start_reg <= open_start_next;
            open_peak_reg <= open_peak_next;
            open_peak_index_reg <= open_peak_index_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/pbs_out_reg.sv
`default_nettype none
module pbs_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pbs_pkg::result_t result,
    output logic                  free,
    pbs_segment_if.source         segments
);
    import pbs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    segment_t segment_reg;

    assign free = !valid_reg || segments.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.produced)
        begin
            valid_next = 1'b1;
        end
        else if (segments.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.produced)
        begin
            segment_reg <= result.segment;
        end
    end

    assign segments.valid = valid_reg;
    assign segments.seg_start = segment_reg.seg_start;
    assign segments.seg_finish = segment_reg.seg_finish;
    assign segments.peak_height = segment_reg.peak_height;
    assign segments.peak_index = segment_reg.peak_index;
    assign segments.seg_frame = segment_reg.seg_frame;
endmodule
`default_nettype wire

FILE: rtl/core/profile_bump_segmenter.sv
// A closing sample is held in the input register, its segment in the output register.
// Throughput: one sample transaction per cycle while the output side keeps up; the
// height and edge logic between the input register and the result register sets this.
// Reset: rst_n clears all valid flags and tracking state at once and restores the
// register defaults; no clearing pass is needed.
`default_nettype none
module profile_bump_segmenter #(
    parameter int SAMPLES_PER_FRAME = 274
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    pbs_sample_if.sink                             samples,
    pbs_segment_if.source                          segments,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pbs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pbs_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    stage_valid;
    sample_t stage_sample;
    logic    out_free;
    logic    advance;
    result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MOUNT_HEIGHT: cfg_next.mount_height = cfg_data;
                CFG_MIN_HEIGHT:   cfg_next.min_height = cfg_data;
                CFG_MIN_WIDTH:    cfg_next.min_width = cfg_data[IDX_W-1:0];
                CFG_WINDOW_FIRST: cfg_next.window_first = cfg_data[IDX_W-1:0];
                CFG_WINDOW_LAST:  cfg_next.window_last = cfg_data[IDX_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mount_height <= '0;
            cfg_reg.min_height <= '0;
            cfg_reg.min_width <= '0;
            cfg_reg.window_first <= WINDOW_FIRST_RESET;
            cfg_reg.window_last <= WINDOW_LAST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign advance = stage_valid && out_free;

    pbs_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples),
        .advance      (advance),
        .stage_valid  (stage_valid),
        .stage_sample (stage_sample)
    );

    pbs_tracker #(
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .advance      (advance),
        .stage_sample (stage_sample),
        .result       (result)
    );

    pbs_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .free     (out_free),
        .segments (segments)
    );
endmodule
`default_nettype wire
